@@ rtl/core/nearest_match_index_finder_defines.svh @@
// assertion macros shared by the nearest match index finder rtl
`ifndef NEAREST_MATCH_INDEX_FINDER_DEFINES_SVH
`define NEAREST_MATCH_INDEX_FINDER_DEFINES_SVH

// same-cycle implication, checked outside reset
`define NMIF_ASSERT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, checked outside reset
`define NMIF_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

@@ rtl/core/nmif_pkg.sv @@
// shared constants and types for the nearest match index finder
`default_nettype none
package nmif_pkg;
   localparam int TABLE_DEPTH = 1024;
   localparam int LINE_BITS   = 20;
   localparam int OFFSET_BITS = 16;
   localparam int STEP_BITS   = 16;

   localparam int KEY_W  = LINE_BITS + OFFSET_BITS;
   localparam int IDX_W  = $clog2(TABLE_DEPTH);
   localparam int CNT_W  = IDX_W + 1;
   localparam int DIVD_W = ((IDX_W > STEP_BITS) ? IDX_W : STEP_BITS) + 1;
   localparam int BIT_W  = $clog2(DIVD_W);

   localparam logic [1:0] OP_CLEAR  = 2'd0;
   localparam logic [1:0] OP_APPEND = 2'd1;
   localparam logic [1:0] OP_QUERY  = 2'd2;

   typedef struct packed {
      logic busy;
      logic done;
   } mod_stat_type;
endpackage
`default_nettype wire

@@ rtl/core/nmif_ram.sv @@
// generic ram with one write port and one registered read port
`default_nettype none
module nmif_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;
endmodule
`default_nettype wire

@@ rtl/core/nmif_mod.sv @@
// bit-serial restoring remainder unit, one dividend bit per cycle
`default_nettype none
`include "nearest_match_index_finder_defines.svh"
module nmif_mod
   import nmif_pkg::*;
(
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              start,
   input  wire logic [DIVD_W-1:0] dividend,
   input  wire logic [CNT_W-1:0]  divisor,
   output mod_stat_type           stat,
   output logic      [CNT_W-1:0]  remainder
);
   logic              busy_ff, busy_in;
   logic              done_ff, done_in;
   logic [CNT_W-1:0]  rem_ff, rem_in;
   logic [DIVD_W-1:0] dvd_ff, dvd_in;
   logic [BIT_W-1:0]  bit_ff, bit_in;
   logic [CNT_W:0]    trial;
   logic [CNT_W:0]    diff;

   always_comb begin
      trial   = {rem_ff, dvd_ff[DIVD_W-1]};
      diff    = trial - {1'b0, divisor};
      busy_in = busy_ff;
      done_in = 1'b0;
      rem_in  = rem_ff;
      dvd_in  = dvd_ff;
      bit_in  = bit_ff;
      if (start) begin
         busy_in = 1'b1;
         rem_in  = '0;
         dvd_in  = dividend;
         bit_in  = BIT_W'(DIVD_W - 1);
      end else if (busy_ff) begin
         // keep the trial difference when the divisor fits
         rem_in = (trial >= {1'b0, divisor}) ? diff[CNT_W-1:0] : trial[CNT_W-1:0];
         dvd_in = {dvd_ff[DIVD_W-2:0], 1'b0};
         bit_in = bit_ff - 1'b1;
         if (bit_ff == '0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      rem_ff <= rem_in;
      dvd_ff <= dvd_in;
      bit_ff <= bit_in;
   end

   assign stat.busy = busy_ff;
   assign stat.done = done_ff;
   assign remainder = rem_ff;

   `NMIF_ASSERT_NEXT(a_start_busy, clock, reset, start, busy_ff, "start did not raise busy")
   `NMIF_ASSERT(a_done_idle, clock, reset, done_ff, !busy_ff, "done while still busy")
endmodule
`default_nettype wire

@@ rtl/core/nearest_match_index_finder.sv @@
// top level: match position table with circular lower-bound search
//
// req channel carries one operation per transfer: clear, append or query.
// rsp channel returns found, match_index and overflow; clear and unknown
// operations return nothing, append and query return exactly one transfer.
// clear and append finish in the cycle of acceptance; the append result is
// loaded into the rsp register at that edge.
// a query runs a halving search over the table ram, each probe issuing an
// address in S_SRCH and comparing the registered read in S_SRCW, up to
// floor(log2(entries))+1 probes, then one read of the lower bound entry,
// a compare in S_CHKW that starts the remainder by the entry count, the
// bit-serial remainder over 17 dividend bits in S_MODW, and S_FIN, which
// loads the rsp register once it is free; an empty table goes from idle
// straight to S_FIN, which loads found low.
// one item at a time: req_ready is high only while idle and the rsp
// register is free or being drained, so a stalled receiver holds back new
// work; results are never dropped or repeated.
// reset empties the table (entry count zero) and clears rsp_valid; the ram
// needs no clearing since entries past the count are never used.
`default_nettype none
`include "nearest_match_index_finder_defines.svh"
module nearest_match_index_finder
   import nmif_pkg::*;
(
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   req_valid,
   output logic                        req_ready,
   input  wire logic [1:0]             req_operation,
   input  wire logic [LINE_BITS-1:0]   req_pos_line,
   input  wire logic [OFFSET_BITS-1:0] req_pos_offset,
   input  wire logic                   req_go_forward,
   input  wire logic [STEP_BITS-1:0]   req_step_count,
   input  wire logic                   req_keep_if_single,
   output logic                        rsp_valid,
   input  wire logic                   rsp_ready,
   output logic                        rsp_found,
   output logic      [IDX_W-1:0]       rsp_match_index,
   output logic                        rsp_overflow
);
   // sequencer states
   localparam logic [2:0] S_IDLE = 3'd0;
   localparam logic [2:0] S_SRCH = 3'd1;  // issue a probe read or the final read
   localparam logic [2:0] S_SRCW = 3'd2;  // compare probe, narrow the range
   localparam logic [2:0] S_CHKW = 3'd3;  // compare entry at lower bound, start modulo
   localparam logic [2:0] S_MODW = 3'd4;  // wait for remainder, wrap the index
   localparam logic [2:0] S_FIN  = 3'd5;  // hand the result to the rsp register

   logic [2:0]           state_ff, state_in;
   logic [CNT_W-1:0]     count_ff, count_in;
   logic [CNT_W-1:0]     first_ff, first_in;
   logic [CNT_W-1:0]     len_ff, len_in;
   logic [CNT_W-1:0]     base_ff, base_in;
   logic [KEY_W-1:0]     key_ff, key_in;
   logic [STEP_BITS-1:0] step_ff, step_in;
   logic                 fwd_ff, fwd_in;
   logic                 keep_ff, keep_in;
   logic                 found_ff, found_in;
   logic [IDX_W-1:0]     idx_ff, idx_in;

   logic                 rsp_valid_ff, rsp_valid_in;
   logic                 rsp_found_ff, rsp_found_in;
   logic [IDX_W-1:0]     rsp_match_index_ff, rsp_match_index_in;
   logic                 rsp_overflow_ff, rsp_overflow_in;

   logic                 slot_free;
   logic                 req_xfer;
   logic                 table_full;
   logic [CNT_W-1:0]     half;
   logic [CNT_W-1:0]     mid;
   logic                 at_end;
   logic                 hit;
   logic                 one_step;
   logic [CNT_W-1:0]     fwd_base;
   logic [CNT_W-1:0]     bwd_base;
   logic [CNT_W:0]       wrap_sum;

   logic                 ram_wr_en;
   logic                 ram_rd_en;
   logic [IDX_W-1:0]     ram_rd_addr;
   logic [KEY_W-1:0]     ram_rd_data;

   logic                 mod_start;
   logic [DIVD_W-1:0]    mod_dividend;
   mod_stat_type         mod_stat;
   logic [CNT_W-1:0]     mod_rem;

   // checked conditions on the outputs
   logic                 count_in_range;
   logic                 index_in_range;
   logic                 found_out;
   logic                 ovf_out;

   assign slot_free  = !rsp_valid_ff || rsp_ready;
   assign req_ready  = (state_ff == S_IDLE) && slot_free;
   assign req_xfer   = req_valid && req_ready;
   assign table_full = (count_ff >= CNT_W'(TABLE_DEPTH));
   assign ram_wr_en  = req_xfer && (req_operation == OP_APPEND) && !table_full;

   // halving search arithmetic
   assign half = len_ff >> 1;
   assign mid  = first_ff + half;

   // lower bound adjustments before the circular step
   assign at_end   = (first_ff >= count_ff);
   assign hit      = !at_end && (ram_rd_data == key_ff);
   assign one_step = (step_ff == STEP_BITS'(1));

   always_comb begin
      if (at_end) begin
         fwd_base = '0;
      end else if (hit && !(keep_ff && one_step)) begin
         fwd_base = (first_ff + 1'b1 == count_ff) ? '0 : first_ff + 1'b1;
      end else begin
         fwd_base = first_ff;
      end
      if (at_end) begin
         bwd_base = count_ff - 1'b1;
      end else if (hit && keep_ff && one_step) begin
         bwd_base = first_ff;
      end else if (first_ff == '0) begin
         bwd_base = count_ff - 1'b1;
      end else begin
         bwd_base = first_ff - 1'b1;
      end
   end

   // backward wrap: base minus remainder, modulo entry count
   assign wrap_sum = {1'b0, base_ff} + {1'b0, count_ff} - {1'b0, mod_rem};

   always_comb begin
      state_in           = state_ff;
      count_in           = count_ff;
      first_in           = first_ff;
      len_in             = len_ff;
      base_in            = base_ff;
      key_in             = key_ff;
      step_in            = step_ff;
      fwd_in             = fwd_ff;
      keep_in            = keep_ff;
      found_in           = found_ff;
      idx_in             = idx_ff;
      rsp_valid_in       = rsp_valid_ff;
      rsp_found_in       = rsp_found_ff;
      rsp_match_index_in = rsp_match_index_ff;
      rsp_overflow_in    = rsp_overflow_ff;
      ram_rd_en          = 1'b0;
      ram_rd_addr        = mid[IDX_W-1:0];
      mod_start          = 1'b0;
      mod_dividend       = DIVD_W'(step_ff) - 1'b1;

      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         S_IDLE: begin
            if (req_xfer) begin
               case (req_operation)
                  OP_CLEAR: begin
                     count_in = '0;
                  end
                  OP_APPEND: begin
                     rsp_valid_in       = 1'b1;
                     rsp_found_in       = 1'b0;
                     rsp_match_index_in = '0;
                     rsp_overflow_in    = table_full;
                     if (!table_full) begin
                        count_in = count_ff + 1'b1;
                     end
                  end
                  OP_QUERY: begin
                     key_in   = {req_pos_line, req_pos_offset};
                     step_in  = (req_step_count == '0) ? STEP_BITS'(1) : req_step_count;
                     fwd_in   = req_go_forward;
                     keep_in  = req_keep_if_single;
                     first_in = '0;
                     len_in   = count_ff;
                     if (count_ff == '0) begin
                        found_in = 1'b0;
                        idx_in   = '0;
                        state_in = S_FIN;
                     end else begin
                        state_in = S_SRCH;
                     end
                  end
                  default: begin
                  end
               endcase
            end
         end
         S_SRCH: begin
            ram_rd_en = 1'b1;
            if (len_ff == '0) begin
               // read the lower bound entry itself; ignored when past the end
               ram_rd_addr = first_ff[IDX_W-1:0];
               state_in    = S_CHKW;
            end else begin
               state_in = S_SRCW;
            end
         end
         S_SRCW: begin
            if (ram_rd_data < key_ff) begin
               first_in = mid + 1'b1;
               len_in   = len_ff - half - 1'b1;
            end else begin
               len_in = half;
            end
            state_in = S_SRCH;
         end
         S_CHKW: begin
            mod_start = 1'b1;
            if (fwd_ff) begin
               base_in      = fwd_base;
               mod_dividend = DIVD_W'(fwd_base) + DIVD_W'(step_ff) - 1'b1;
            end else begin
               base_in = bwd_base;
            end
            state_in = S_MODW;
         end
         S_MODW: begin
            if (mod_stat.done) begin
               found_in = 1'b1;
               if (fwd_ff) begin
                  idx_in = mod_rem[IDX_W-1:0];
               end else if (mod_rem <= base_ff) begin
                  idx_in = IDX_W'(base_ff - mod_rem);
               end else begin
                  idx_in = wrap_sum[IDX_W-1:0];
               end
               state_in = S_FIN;
            end
         end
         S_FIN: begin
            if (slot_free) begin
               rsp_valid_in       = 1'b1;
               rsp_found_in       = found_ff;
               rsp_match_index_in = idx_ff;
               rsp_overflow_in    = 1'b0;
               state_in           = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      first_ff           <= first_in;
      len_ff             <= len_in;
      base_ff            <= base_in;
      key_ff             <= key_in;
      step_ff            <= step_in;
      fwd_ff             <= fwd_in;
      keep_ff            <= keep_in;
      found_ff           <= found_in;
      idx_ff             <= idx_in;
      rsp_found_ff       <= rsp_found_in;
      rsp_match_index_ff <= rsp_match_index_in;
      rsp_overflow_ff    <= rsp_overflow_in;
   end

   // match position table
   nmif_ram #(
      .WIDTH(KEY_W),
      .DEPTH(TABLE_DEPTH)
   ) u_table (
      .clock  (clock),
      .wr_en  (ram_wr_en),
      .wr_addr(count_ff[IDX_W-1:0]),
      .wr_data({req_pos_line, req_pos_offset}),
      .rd_en  (ram_rd_en),
      .rd_addr(ram_rd_addr),
      .rd_data(ram_rd_data)
   );

   // shared remainder unit for the circular step
   nmif_mod u_mod (
      .clock    (clock),
      .reset    (reset),
      .start    (mod_start),
      .dividend (mod_dividend),
      .divisor  (count_ff),
      .stat     (mod_stat),
      .remainder(mod_rem)
   );

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_found       = rsp_found_ff;
   assign rsp_match_index = rsp_match_index_ff;
   assign rsp_overflow    = rsp_overflow_ff;

   assign count_in_range = (count_ff <= CNT_W'(TABLE_DEPTH));
   assign index_in_range = ({1'b0, rsp_match_index_ff} < count_ff);
   assign found_out      = rsp_valid_ff && rsp_found_ff;
   assign ovf_out        = rsp_valid_ff && rsp_overflow_ff;

   `NMIF_ASSERT(a_count_max, clock, reset, 1'b1, count_in_range, "entry count above depth")
   `NMIF_ASSERT(a_found_range, clock, reset, found_out, index_in_range, "index past count")
   `NMIF_ASSERT(a_found_ovf, clock, reset, ovf_out, !rsp_found_ff, "overflow with found")
   `NMIF_ASSERT(a_mod_state, clock, reset, mod_stat.busy, state_ff == S_MODW, "busy outside wait")
endmodule
`default_nettype wire
